@@ sv/pol_pkg.sv @@
// ----------------------------------------------------------------------------
// pol_pkg
// Shared constants, request and error codes, and the command and status
// types that join the positional list controller and datapath.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int REQ_W    = 3;
  localparam int ERR_W    = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REM_VAL  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FULL    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_POS     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_MISSING = 3'd4;

  typedef enum logic [2:0] {
    RS_IDX    = 3'd0,
    RS_IDX_M1 = 3'd1,
    RS_IDX_P1 = 3'd2,
    RS_POS    = 3'd3,
    RS_HEAD   = 3'd4,
    RS_TAIL   = 3'd5
  } rsel_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_CNT  = 3'd1,
    IDX_ZERO = 3'd2,
    IDX_HIT  = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_op_e;

  typedef struct packed {
    logic             load;
    logic             rd;
    rsel_e            rsel;
    logic             mv;
    logic             cmp;
    idx_op_e          idx_op;
    logic             wr_val;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             err_ld;
    logic [ERR_W-1:0] err;
    logic             hit_ld;
    logic             data_ld;
    logic             head_ld;
    logic             out_ld;
  } pol_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [ERR_W-1:0] chk_err;
    logic             up_more;
    logic             dn_more;
    logic             scan_more;
    logic             hit;
  } pol_sts_t;

endpackage

@@ sv/pol_in_if.sv @@
// ----------------------------------------------------------------------------
// pol_in_if
// Request channel of the positional list: valid, ready and one request beat.
// ----------------------------------------------------------------------------
interface pol_in_if;

  logic                        valid;
  logic                        ready;
  logic [pol_pkg::REQ_W-1:0]   req_type;
  logic [pol_pkg::DATA_W-1:0]  value;
  logic [pol_pkg::POS_W-1:0]   position;

  modport source (output valid, output req_type, output value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input value, input position,
                  output ready);

endinterface

@@ sv/pol_out_if.sv @@
// ----------------------------------------------------------------------------
// pol_out_if
// Result channel of the positional list: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface pol_out_if;

  logic                        valid;
  logic                        ready;
  logic [pol_pkg::DATA_W-1:0]  data_out;
  logic [pol_pkg::POS_W-1:0]   found_pos;
  logic                        found;
  logic [pol_pkg::ERR_W-1:0]   error_code;
  logic [pol_pkg::CNT_W-1:0]   entry_count;
  logic                        is_empty;
  logic [pol_pkg::DATA_W-1:0]  head_value;
  logic [pol_pkg::DATA_W-1:0]  tail_value;

  modport source (output valid, output data_out, output found_pos, output found,
                  output error_code, output entry_count, output is_empty,
                  output head_value, output tail_value, input ready);
  modport sink   (input valid, input data_out, input found_pos, input found,
                  input error_code, input entry_count, input is_empty,
                  input head_value, input tail_value, output ready);

endinterface

@@ sv/pol_datapath.sv @@
// ----------------------------------------------------------------------------
// pol_datapath
// Entry memory, occupancy, walk index, request capture and result register
// of the positional list. Executes one command word per cycle.
// ----------------------------------------------------------------------------
module pol_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pol_pkg::REQ_W-1:0]   req_type_i,
  input  logic [pol_pkg::DATA_W-1:0]  value_i,
  input  logic [pol_pkg::POS_W-1:0]   position_i,
  input  pol_pkg::pol_cmd_t           cmd_i,
  output pol_pkg::pol_sts_t           sts_o,
  output logic [pol_pkg::DATA_W-1:0]  data_out_o,
  output logic [pol_pkg::POS_W-1:0]   found_pos_o,
  output logic                        found_o,
  output logic [pol_pkg::ERR_W-1:0]   error_code_o,
  output logic [pol_pkg::CNT_W-1:0]   entry_count_o,
  output logic                        is_empty_o,
  output logic [pol_pkg::DATA_W-1:0]  head_value_o,
  output logic [pol_pkg::DATA_W-1:0]  tail_value_o
);

  logic [pol_pkg::DATA_W-1:0] mem [pol_pkg::CAPACITY];

  logic [pol_pkg::REQ_W-1:0]  req_q;
  logic [pol_pkg::DATA_W-1:0] val_q;
  logic [pol_pkg::POS_W-1:0]  pos_q;
  logic [pol_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pol_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                       pend_q;
  logic [pol_pkg::IDX_W-1:0]  paddr_q;
  logic                       cmp_q;
  logic [pol_pkg::IDX_W-1:0]  cidx_q;
  logic [pol_pkg::DATA_W-1:0] rdata_q;
  logic [pol_pkg::DATA_W-1:0] data_q;
  logic [pol_pkg::POS_W-1:0]  fpos_q;
  logic                       fnd_q;
  logic [pol_pkg::ERR_W-1:0]  err_q;
  logic [pol_pkg::DATA_W-1:0] head_q;

  logic [pol_pkg::CNT_W-1:0]  idx_m1, idx_p1, pos_m1, cnt_m1;
  logic [pol_pkg::CNT_W:0]    cnt_p1;
  logic [pol_pkg::IDX_W-1:0]  raddr, waddr;
  logic [pol_pkg::DATA_W-1:0] wdata;
  logic                       wr_en;
  logic                       empty;
  logic                       pos_zero;
  logic [pol_pkg::ERR_W-1:0]  chk_err;

  assign idx_m1   = idx_q - 1'b1;
  assign idx_p1   = idx_q + 1'b1;
  assign pos_m1   = pos_q - 1'b1;
  assign cnt_m1   = cnt_q - 1'b1;
  assign cnt_p1   = {1'b0, cnt_q} + 1'b1;
  assign empty    = (cnt_q == '0);
  assign pos_zero = (pos_q == '0);

  always_comb begin
    chk_err = pol_pkg::ERR_OK;
    case (req_q)
      pol_pkg::REQ_INSERT: begin
        if (cnt_q >= pol_pkg::CNT_W'(pol_pkg::CAPACITY)) begin
          chk_err = pol_pkg::ERR_FULL;
        end else if (pos_zero || ({1'b0, pos_q} > cnt_p1)) begin
          chk_err = pol_pkg::ERR_POS;
        end
      end
      pol_pkg::REQ_READ: begin
        if (empty) begin
          chk_err = pol_pkg::ERR_EMPTY;
        end else if (pos_zero || (pos_q > cnt_q)) begin
          chk_err = pol_pkg::ERR_POS;
        end
      end
      pol_pkg::REQ_FIND, pol_pkg::REQ_REM_HEAD, pol_pkg::REQ_REM_VAL: begin
        if (empty) begin
          chk_err = pol_pkg::ERR_EMPTY;
        end
      end
      default: chk_err = pol_pkg::ERR_OK;
    endcase
  end

  assign sts_o.req       = req_q;
  assign sts_o.chk_err   = chk_err;
  assign sts_o.up_more   = (idx_q >= pos_q);
  assign sts_o.dn_more   = (idx_p1 < cnt_q);
  assign sts_o.scan_more = (idx_q < cnt_q);
  assign sts_o.hit       = cmp_q && (rdata_q == val_q);

  always_comb begin
    case (cmd_i.rsel)
      pol_pkg::RS_IDX:    raddr = idx_q[pol_pkg::IDX_W-1:0];
      pol_pkg::RS_IDX_M1: raddr = idx_m1[pol_pkg::IDX_W-1:0];
      pol_pkg::RS_IDX_P1: raddr = idx_p1[pol_pkg::IDX_W-1:0];
      pol_pkg::RS_POS:    raddr = pos_m1[pol_pkg::IDX_W-1:0];
      pol_pkg::RS_TAIL:   raddr = cnt_m1[pol_pkg::IDX_W-1:0];
      default:            raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.idx_op)
      pol_pkg::IDX_CNT:  idx_d = cnt_q;
      pol_pkg::IDX_ZERO: idx_d = '0;
      pol_pkg::IDX_HIT:  idx_d = pol_pkg::CNT_W'(cidx_q);
      pol_pkg::IDX_INC:  idx_d = idx_p1;
      pol_pkg::IDX_DEC:  idx_d = idx_m1;
      default:           idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_p1[pol_pkg::CNT_W-1:0];
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  // A pending entry move always wins the write port; the controller never
  // asks for a value write in the cycle that drains the last move.
  assign wr_en = pend_q || cmd_i.wr_val;
  assign waddr = pend_q ? paddr_q : pos_m1[pol_pkg::IDX_W-1:0];
  assign wdata = pend_q ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      pend_q <= 1'b0;
      cmp_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      pend_q <= cmd_i.mv;
      cmp_q  <= cmd_i.cmp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mv) begin
      paddr_q <= idx_q[pol_pkg::IDX_W-1:0];
    end
    if (cmd_i.cmp) begin
      cidx_q <= idx_q[pol_pkg::IDX_W-1:0];
    end
    if (cmd_i.head_ld) begin
      head_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      val_q  <= value_i;
      pos_q  <= position_i;
      data_q <= '0;
      fpos_q <= '0;
      fnd_q  <= 1'b0;
      err_q  <= pol_pkg::ERR_OK;
    end else begin
      if (cmd_i.err_ld) begin
        err_q <= cmd_i.err;
      end
      if (cmd_i.hit_ld) begin
        fnd_q  <= 1'b1;
        fpos_q <= pol_pkg::POS_W'(cidx_q) + 1'b1;
      end
      if (cmd_i.data_ld) begin
        data_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      data_out_o    <= data_q;
      found_pos_o   <= fpos_q;
      found_o       <= fnd_q;
      error_code_o  <= err_q;
      entry_count_o <= cnt_q;
      is_empty_o    <= empty;
      head_value_o  <= empty ? '0 : head_q;
      tail_value_o  <= empty ? '0 : rdata_q;
    end
  end

endmodule

@@ sv/pol_ctrl.sv @@
// ----------------------------------------------------------------------------
// pol_ctrl
// Sequencer of the positional list: decodes each request, walks the entry
// memory through the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pol_pkg::pol_sts_t  sts_i,
  output pol_pkg::pol_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_SHIFT_UP = 10'b00_0000_0100,
    S_INS_WR   = 10'b00_0000_1000,
    S_SCAN     = 10'b00_0001_0000,
    S_SHIFT_DN = 10'b00_0010_0000,
    S_RDATA    = 10'b00_0100_0000,
    S_HEAD     = 10'b00_1000_0000,
    S_TAIL     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.chk_err != pol_pkg::ERR_OK) begin
          cmd_o.err_ld = 1'b1;
          cmd_o.err    = sts_i.chk_err;
          state_d      = S_HEAD;
        end else begin
          case (sts_i.req)
            pol_pkg::REQ_INSERT: begin
              cmd_o.idx_op = pol_pkg::IDX_CNT;
              state_d      = S_SHIFT_UP;
            end
            pol_pkg::REQ_READ: begin
              cmd_o.rd   = 1'b1;
              cmd_o.rsel = pol_pkg::RS_POS;
              state_d    = S_RDATA;
            end
            pol_pkg::REQ_FIND, pol_pkg::REQ_REM_VAL: begin
              cmd_o.idx_op = pol_pkg::IDX_ZERO;
              state_d      = S_SCAN;
            end
            pol_pkg::REQ_REM_HEAD: begin
              cmd_o.idx_op = pol_pkg::IDX_ZERO;
              state_d      = S_SHIFT_DN;
            end
            default: state_d = S_HEAD;
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (sts_i.up_more) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rsel   = pol_pkg::RS_IDX_M1;
          cmd_o.mv     = 1'b1;
          cmd_o.idx_op = pol_pkg::IDX_DEC;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_val  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_HEAD;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          if (sts_i.req == pol_pkg::REQ_FIND) begin
            cmd_o.hit_ld = 1'b1;
            state_d      = S_HEAD;
          end else begin
            cmd_o.idx_op = pol_pkg::IDX_HIT;
            state_d      = S_SHIFT_DN;
          end
        end else if (sts_i.scan_more) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rsel   = pol_pkg::RS_IDX;
          cmd_o.cmp    = 1'b1;
          cmd_o.idx_op = pol_pkg::IDX_INC;
        end else begin
          cmd_o.err_ld = 1'b1;
          cmd_o.err    = pol_pkg::ERR_MISSING;
          state_d      = S_HEAD;
        end
      end
      S_SHIFT_DN: begin
        if (sts_i.dn_more) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rsel   = pol_pkg::RS_IDX_P1;
          cmd_o.mv     = 1'b1;
          cmd_o.idx_op = pol_pkg::IDX_INC;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_HEAD;
        end
      end
      S_RDATA: begin
        cmd_o.data_ld = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.rsel    = pol_pkg::RS_HEAD;
        state_d       = S_TAIL;
      end
      S_HEAD: begin
        cmd_o.rd   = 1'b1;
        cmd_o.rsel = pol_pkg::RS_HEAD;
        state_d    = S_TAIL;
      end
      S_TAIL: begin
        cmd_o.head_ld = 1'b1;
        cmd_o.rd      = 1'b1;
        cmd_o.rsel    = pol_pkg::RS_TAIL;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/positional_ordered_list_core.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// Bounded ordered list with 1-based positions: insert, read, find, remove
// head and remove value, each answered by one result beat with list status.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_i     in   valid / ready      req_type, value, position
//  out_o    out  valid / ready      data_out, found_pos, found, error_code,
//                                   entry_count, is_empty, head_value,
//                                   tail_value
//
// One request is in work at a time. A rejected or unused request goes from
// decode to the head and tail reads and the result register; a read first
// fetches its entry. Insert at position p shifts entries up, then writes;
// removal at 1-based index m moves the entries above m down; a find or value
// removal first compares from the head, as the one-read, one-write entry
// memory moves or compares one entry per cycle. A new request is accepted
// while the previous result waits on out_o; the sequencer holds its last
// step until out_o is free. Reset empties the list at once.
module positional_ordered_list_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pol_in_if.sink     in_i,
  pol_out_if.source  out_o
);

  pol_pkg::pol_cmd_t cmd;
  pol_pkg::pol_sts_t sts;

  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pol_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (in_i.req_type),
    .value_i       (in_i.value),
    .position_i    (in_i.position),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_out_o    (out_o.data_out),
    .found_pos_o   (out_o.found_pos),
    .found_o       (out_o.found),
    .error_code_o  (out_o.error_code),
    .entry_count_o (out_o.entry_count),
    .is_empty_o    (out_o.is_empty),
    .head_value_o  (out_o.head_value),
    .tail_value_o  (out_o.tail_value)
  );

endmodule

@@ sv/pol_checker.sv @@
// ----------------------------------------------------------------------------
// pol_checker
// Port-level checks on the result channel of the positional list.
// ----------------------------------------------------------------------------
module pol_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [pol_pkg::POS_W-1:0]   found_pos_i,
  input  logic                        found_i,
  input  logic [pol_pkg::ERR_W-1:0]   error_code_i,
  input  logic [pol_pkg::CNT_W-1:0]   entry_count_i,
  input  logic                        is_empty_i,
  input  logic [pol_pkg::DATA_W-1:0]  head_value_i,
  input  logic [pol_pkg::DATA_W-1:0]  tail_value_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(entry_count_i))
    else $error("result beat dropped or changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (entry_count_i == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |-> (head_value_i == '0) && (tail_value_i == '0))
    else $error("empty list reports a head or tail value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> (error_code_i == pol_pkg::ERR_OK) && (found_pos_i != '0))
    else $error("found result with error or null position");

endmodule

bind positional_ordered_list_core pol_checker u_pol_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_pos_i   (out_o.found_pos),
  .found_i       (out_o.found),
  .error_code_i  (out_o.error_code),
  .entry_count_i (out_o.entry_count),
  .is_empty_i    (out_o.is_empty),
  .head_value_i  (out_o.head_value),
  .tail_value_i  (out_o.tail_value)
);
